>>> hdl/atac_pkg.sv
// Shared types and constants for the accelerometer tilt-average classifier.
// Holds the word structs, the register map, the FSM state enum and the atan table.
// No dependencies; every other file of the block imports this package.
package atac_pkg;

  // Fraction bits of the angle accumulator inside the CORDIC (degrees).
  localparam int ACC_FRAC  = 22;
  localparam int TABLE_LEN = 24;
  localparam int IDX_W     = 5;
  localparam int SUM_W     = 24;
  localparam int CNT_W     = 8;
  localparam int DIV_STEPS = 24;
  localparam int XY_W      = 20;
  localparam int ACC_W     = 32;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // atan(2^-i) in degrees with ACC_FRAC fraction bits.
  localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  typedef enum logic [2:0] {
    REG_WINDOW_LEN    = 3'd0,
    REG_Z_OFFSET      = 3'd1,
    REG_YELLOW_LOW    = 3'd2,
    REG_YELLOW_HIGH   = 3'd3,
    REG_BLUE_POS_LOW  = 3'd4,
    REG_BLUE_NEG_HIGH = 3'd5
  } reg_idx_e;

  localparam logic [7:0]         RST_WINDOW_LEN    = 8'd10;
  localparam logic signed [13:0] RST_Z_OFFSET      = 14'sd334;
  localparam logic signed [15:0] RST_YELLOW_LOW    = -16'sd6912;
  localparam logic signed [15:0] RST_YELLOW_HIGH   = 16'sd7424;
  localparam logic signed [15:0] RST_BLUE_POS_LOW  = 16'sd15744;
  localparam logic signed [15:0] RST_BLUE_NEG_HIGH = -16'sd15616;

  typedef struct packed {
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
  } in_word_t;

  typedef struct packed {
    logic               ready_res;
    logic signed [15:0] avg_angle;
    logic               yellow_flag;
    logic               blue_flag;
  } out_word_t;

  typedef struct packed {
    logic [7:0]         window_len;
    logic signed [13:0] z_offset;
    logic signed [15:0] yellow_low;
    logic signed [15:0] yellow_high;
    logic signed [15:0] blue_pos_low;
    logic signed [15:0] blue_neg_high;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ROUND,
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_SIGN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             load_in;
    logic             cordic_step;
    logic             round;
    logic             accum;
    logic             div_init;
    logic             div_step;
    logic             sign_fix;
    logic             load_out;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic y_zero;
    logic fire;
  } status_t;

endpackage

>>> hdl/atac_regs.sv
// Configuration register file behind an APB-style port.
// Depends on atac_pkg for the register map, reset values and cfg_t.
module atac_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [atac_pkg::ADDR_W-1:0]   paddr,
  input  logic [atac_pkg::DATA_W-1:0]   pwdata,
  output logic [atac_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output atac_pkg::cfg_t                cfg_o
);
  import atac_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx_e'(reg_idx))
        REG_WINDOW_LEN:    cfg_d.window_len    = pwdata[7:0];
        REG_Z_OFFSET:      cfg_d.z_offset      = pwdata[13:0];
        REG_YELLOW_LOW:    cfg_d.yellow_low    = pwdata[15:0];
        REG_YELLOW_HIGH:   cfg_d.yellow_high   = pwdata[15:0];
        REG_BLUE_POS_LOW:  cfg_d.blue_pos_low  = pwdata[15:0];
        REG_BLUE_NEG_HIGH: cfg_d.blue_neg_high = pwdata[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(reg_idx))
      REG_WINDOW_LEN:    prdata = {24'd0, cfg_q.window_len};
      REG_Z_OFFSET:      prdata = {{18{cfg_q.z_offset[13]}}, cfg_q.z_offset};
      REG_YELLOW_LOW:    prdata = {{16{cfg_q.yellow_low[15]}}, cfg_q.yellow_low};
      REG_YELLOW_HIGH:   prdata = {{16{cfg_q.yellow_high[15]}}, cfg_q.yellow_high};
      REG_BLUE_POS_LOW:  prdata = {{16{cfg_q.blue_pos_low[15]}}, cfg_q.blue_pos_low};
      REG_BLUE_NEG_HIGH: prdata = {{16{cfg_q.blue_neg_high[15]}}, cfg_q.blue_neg_high};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len    <= RST_WINDOW_LEN;
      cfg_q.z_offset      <= RST_Z_OFFSET;
      cfg_q.yellow_low    <= RST_YELLOW_LOW;
      cfg_q.yellow_high   <= RST_YELLOW_HIGH;
      cfg_q.blue_pos_low  <= RST_BLUE_POS_LOW;
      cfg_q.blue_neg_high <= RST_BLUE_NEG_HIGH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/atac_datapath.sv
// Datapath: iterative CORDIC atan2, rounding, saturating window sum,
// serial restoring divider, classification and the output word register.
// Depends on atac_pkg; driven by the command struct from atac_ctrl.
module atac_datapath #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atac_pkg::cfg_t      cfg_i,
  input  atac_pkg::cmd_t      cmd_i,
  output atac_pkg::status_t   status_o,
  input  atac_pkg::in_word_t  in_data_i,
  output atac_pkg::out_word_t out_data_o
);
  import atac_pkg::*;

  localparam int ANG_W  = ANGLE_FRAC_BITS + 10;
  localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
  localparam logic signed [ACC_W-1:0] HALF_TURN = 32'sd180 <<< ACC_FRAC;
  localparam logic signed [ACC_W-1:0] FULL      = 32'sd180 <<< ANGLE_FRAC_BITS;

  // CORDIC working registers.
  logic signed [XY_W-1:0]  x_q, y_q, x_d, y_d;
  logic signed [ACC_W-1:0] ang_q, ang_d;
  // Rounded angle as magnitude and sign.
  logic [ANG_W-1:0]        mag_q;
  logic                    neg_q;
  // Window state.
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        samples_q, samples_d;
  logic                    fire_q, fire_d;
  // Divider.
  logic [DIV_STEPS-1:0]    quo_q;
  logic [CNT_W-1:0]        rem_q, divisor_q;
  logic                    sneg_q;
  logic signed [15:0]      avg_q;
  out_word_t               out_q;

  // Load and step terms.
  logic signed [XY_W-1:0]  y_ext, zc, xs, ys;
  logic [ACC_W-1:0]        ang_abs, rnd_sum;
  logic signed [SUM_W:0]   sum_ext, mag_ext, sum_add;
  logic [CNT_W-1:0]        count_next, win;
  logic                    fire_now;
  logic [SUM_W-1:0]        sum_abs, dividend;
  logic [CNT_W:0]          rem_sh, rem_sub;
  logic signed [ACC_W-1:0] avg_ext, yl_ext, yh_ext, bp_ext, bn_ext;
  logic                    yel, blu;

  assign y_ext = {{(XY_W-16){in_data_i.accel_y_raw[15]}}, in_data_i.accel_y_raw};
  assign zc    = {{(XY_W-16){in_data_i.accel_z_raw[15]}}, in_data_i.accel_z_raw}
               - {{(XY_W-14){cfg_i.z_offset[13]}}, cfg_i.z_offset};
  assign xs    = x_q >>> cmd_i.idx;
  assign ys    = y_q >>> cmd_i.idx;

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    ang_d = ang_q;
    if (cmd_i.load_in) begin
      // A vector in the left half plane is rotated by half a turn first.
      if (zc[XY_W-1]) begin
        x_d   = -zc;
        y_d   = -y_ext;
        ang_d = y_ext[XY_W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
        x_d   = zc;
        y_d   = y_ext;
        ang_d = '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (!y_q[XY_W-1]) begin
        x_d   = x_q + ys;
        y_d   = y_q - xs;
        ang_d = ang_q + ATAN_TAB[cmd_i.idx];
      end else begin
        x_d   = x_q - ys;
        y_d   = y_q + xs;
        ang_d = ang_q - ATAN_TAB[cmd_i.idx];
      end
    end
  end

  // Round half away from zero to the output fraction.
  assign ang_abs = ang_q[ACC_W-1] ? ACC_W'(-ang_q) : ACC_W'(ang_q);
  assign rnd_sum = ang_abs + RND_HALF;

  // Saturating accumulation and window count.
  assign sum_ext    = {sum_q[SUM_W-1], sum_q};
  assign mag_ext    = {{(SUM_W+1-ANG_W){1'b0}}, mag_q};
  assign sum_add    = neg_q ? (sum_ext - mag_ext) : (sum_ext + mag_ext);
  assign count_next = samples_q + CNT_W'(1);
  assign win        = (cfg_i.window_len == '0) ? CNT_W'(1) : cfg_i.window_len;
  assign fire_now   = (count_next != '0) && (count_next >= win);

  assign sum_abs  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign dividend = sum_abs + SUM_W'(samples_q[CNT_W-1:1]);
  assign rem_sh   = {rem_q, quo_q[DIV_STEPS-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor_q};

  always_comb begin
    sum_d     = sum_q;
    samples_d = samples_q;
    fire_d    = fire_q;
    if (cmd_i.accum) begin
      fire_d    = fire_now;
      samples_d = count_next;
      if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
        sum_d = sum_add[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        sum_d = sum_add[SUM_W-1:0];
      end
    end else if (cmd_i.div_init) begin
      sum_d     = '0;
      samples_d = '0;
    end
  end

  assign avg_ext = {{(ACC_W-16){avg_q[15]}}, avg_q};
  assign yl_ext  = {{(ACC_W-16){cfg_i.yellow_low[15]}}, cfg_i.yellow_low};
  assign yh_ext  = {{(ACC_W-16){cfg_i.yellow_high[15]}}, cfg_i.yellow_high};
  assign bp_ext  = {{(ACC_W-16){cfg_i.blue_pos_low[15]}}, cfg_i.blue_pos_low};
  assign bn_ext  = {{(ACC_W-16){cfg_i.blue_neg_high[15]}}, cfg_i.blue_neg_high};
  assign yel     = (avg_ext >= yl_ext) && (avg_ext <= yh_ext);
  assign blu     = ((avg_ext >= -FULL) && (avg_ext <= bn_ext)) ||
                   ((avg_ext >= bp_ext) && (avg_ext <= FULL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      samples_q <= '0;
      fire_q    <= 1'b0;
    end else begin
      sum_q     <= sum_d;
      samples_q <= samples_d;
      fire_q    <= fire_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
    if (cmd_i.round) begin
      mag_q <= rnd_sum[RND_SH +: ANG_W];
      neg_q <= ang_q[ACC_W-1];
    end
    if (cmd_i.div_init) begin
      quo_q     <= dividend;
      rem_q     <= '0;
      divisor_q <= samples_q;
      sneg_q    <= sum_q[SUM_W-1];
    end else if (cmd_i.div_step) begin
      if (!rem_sub[CNT_W]) begin
        rem_q <= rem_sub[CNT_W-1:0];
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CNT_W-1:0];
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
      end
    end
    if (cmd_i.sign_fix) begin
      if (sneg_q) begin
        avg_q <= (quo_q > DIV_STEPS'(32768)) ? -16'sd32768 : -quo_q[15:0];
      end else begin
        avg_q <= (quo_q > DIV_STEPS'(32767)) ? 16'sd32767 : quo_q[15:0];
      end
    end
    if (cmd_i.load_out) begin
      if (fire_q) begin
        out_q.ready_res   <= 1'b1;
        out_q.avg_angle   <= avg_q;
        out_q.yellow_flag <= yel;
        out_q.blue_flag   <= blu;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign status_o.y_zero = (y_q == '0);
  assign status_o.fire   = fire_now;
  assign out_data_o      = out_q;

`ifndef NO_ASSERTIONS
  // Outside a completed window the count never rests at its top value, since
  // that count always completes a window.
  a_count_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_q |-> (samples_q != {CNT_W{1'b1}}))
    else $error("window count reached its top value");

  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cordic_step |-> !x_q[XY_W-1])
    else $error("CORDIC x went negative");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < divisor_q))
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> hdl/atac_ctrl.sv
// Controller state machine: sequences CORDIC, accumulation, division and output.
// Depends on atac_pkg for state_e, cmd_t and status_t.
module atac_ctrl #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  atac_pkg::status_t  status_i,
  output atac_pkg::cmd_t     cmd_o
);
  import atac_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        // Stop after the last iteration or as soon as y has reached zero.
        if (cnt_q == IDX_W'(CORDIC_ITERATIONS) || status_i.y_zero) begin
          state_d = ST_ROUND;
        end else begin
          cmd_o.cordic_step = 1'b1;
          cnt_d             = cnt_q + IDX_W'(1);
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.fire ? ST_DIV_INIT : ST_FINISH;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == IDX_W'(DIV_STEPS - 1)) begin
          state_d = ST_SIGN;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_SIGN: begin
        cmd_o.sign_fix = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        // The output register is free once its previous word has been taken.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_cordic_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORDIC) |-> (cnt_q <= IDX_W'(CORDIC_ITERATIONS)))
    else $error("CORDIC iteration count out of range");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> (cnt_q < IDX_W'(DIV_STEPS)))
    else $error("divider step count out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CORDIC) && (cnt_q == '0))
    else $error("accepted word did not start the CORDIC");
`endif

endmodule

>>> hdl/accel_tilt_average_classifier.sv
// Top level of the accelerometer tilt-average classifier.
// Depends on atac_pkg, atac_regs, atac_ctrl and atac_datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_ready_o  in_data_i  (in_word_t)
//   output    out        out_valid_o/out_ready_i out_data_o (out_word_t)
//   config    in/out     APB psel/penable/pready paddr, pwdata, prdata
//
// One word is processed at a time. A word passes through the CORDIC iteration loop,
// rounding and accumulation and, when it completes a window, the 24-step serial
// divider and the sign fix before its result is loaded into the output register.
// The next word can be accepted in the cycle after the result is loaded.
// Reset clears the window sum and count and loads the register reset values.
// A waiting result holds in the output register; the next word is taken meanwhile.
module accel_tilt_average_classifier #(
  parameter int ANGLE_FRAC_BITS   = 7,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  atac_pkg::in_word_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output atac_pkg::out_word_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [atac_pkg::ADDR_W-1:0]  paddr,
  input  logic [atac_pkg::DATA_W-1:0]  pwdata,
  output logic [atac_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import atac_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  atac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  atac_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  atac_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> test/atac_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the accelerometer tilt-average classifier.
// Watches the sample, result and register channels and predicts every result word.
// Depends on atac_pkg for the word structs, register indexes and the atan table.
module atac_result_checker
  import atac_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS   = 7,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_word_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_word_t         out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output int                mismatch_cnt_o,
  output int                pending_o
);

  localparam int REPORT_LIMIT = 10;

  cfg_t                   shadow_cfg;
  logic signed [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0]        win_count;
  out_word_t               expected_words[$];
  int                      word_idx;

  // Vectoring CORDIC: angle of (x, y) in degrees with ANGLE_FRAC_BITS fraction bits.
  function automatic longint tilt_angle_q(longint y, longint x);
    longint ang;
    longint xs;
    longint ys;
    longint mag;
    int     sh;
    ang = 0;
    sh  = ACC_FRAC - ANGLE_FRAC_BITS;
    if (x == 0 && y == 0) return 0;
    // Left half plane: rotate by 180 degrees first so the iterations converge.
    if (x < 0) begin
      ang = (y >= 0) ? (longint'(180) <<< ACC_FRAC) : -(longint'(180) <<< ACC_FRAC);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < TABLE_LEN; i++) begin
      if (y == 0) break;
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x   += ys;
        y   -= xs;
        ang += ATAN_TAB[i];
      end else begin
        x   -= ys;
        y   += xs;
        ang -= ATAN_TAB[i];
      end
    end
    mag = (ang < 0) ? -ang : ang;
    mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return (ang < 0) ? -mag : mag;
  endfunction

  // Adds one sample to the window and returns the word the block should emit.
  function automatic out_word_t accumulate_sample(in_word_t w);
    longint    y;
    longint    x;
    longint    sum;
    longint    mag;
    longint    avg;
    longint    full;
    int        win;
    int        cnt;
    out_word_t r;
    y    = longint'(w.accel_y_raw);
    x    = longint'(w.accel_z_raw) - longint'(shadow_cfg.z_offset);
    full = longint'(180) <<< ANGLE_FRAC_BITS;
    sum  = longint'(win_sum) + tilt_angle_q(y, x);
    if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
    if (sum < longint'(SUM_MIN)) sum = longint'(SUM_MIN);
    win_sum   = sum[SUM_W-1:0];
    win_count = win_count + 1'b1;
    cnt       = int'(win_count);
    win       = (shadow_cfg.window_len == 0) ? 1 : int'(shadow_cfg.window_len);
    r         = '0;
    if (cnt >= win && cnt != 0) begin
      mag = (sum < 0) ? -sum : sum;
      avg = (mag + cnt / 2) / cnt;
      if (sum < 0) avg = -avg;
      if (avg > 32767) avg = 32767;
      if (avg < -32768) avg = -32768;
      r.ready_res   = 1'b1;
      r.avg_angle   = avg[15:0];
      r.yellow_flag = avg >= longint'(shadow_cfg.yellow_low) &&
                      avg <= longint'(shadow_cfg.yellow_high);
      r.blue_flag   = (avg >= -full && avg <= longint'(shadow_cfg.blue_neg_high)) ||
                      (avg >= longint'(shadow_cfg.blue_pos_low) && avg <= full);
      win_sum   = '0;
      win_count = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      shadow_cfg.window_len    = RST_WINDOW_LEN;
      shadow_cfg.z_offset      = RST_Z_OFFSET;
      shadow_cfg.yellow_low    = RST_YELLOW_LOW;
      shadow_cfg.yellow_high   = RST_YELLOW_HIGH;
      shadow_cfg.blue_pos_low  = RST_BLUE_POS_LOW;
      shadow_cfg.blue_neg_high = RST_BLUE_NEG_HIGH;
      win_sum        = '0;
      win_count      = '0;
      word_idx       = 0;
      mismatch_cnt_o = 0;
      expected_words.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_WINDOW_LEN:    shadow_cfg.window_len    = pwdata_i[7:0];
          REG_Z_OFFSET:      shadow_cfg.z_offset      = pwdata_i[13:0];
          REG_YELLOW_LOW:    shadow_cfg.yellow_low    = pwdata_i[15:0];
          REG_YELLOW_HIGH:   shadow_cfg.yellow_high   = pwdata_i[15:0];
          REG_BLUE_POS_LOW:  shadow_cfg.blue_pos_low  = pwdata_i[15:0];
          REG_BLUE_NEG_HIGH: shadow_cfg.blue_neg_high = pwdata_i[15:0];
          default: ;
        endcase
      end
      // The result side is handled first; a word never leaves in the cycle it enters.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          if (mismatch_cnt_o < REPORT_LIMIT)
            $display("result word %0d unexpected: ready=%0b avg=%0d y=%0b b=%0b",
                     word_idx, out_data_i.ready_res, out_data_i.avg_angle,
                     out_data_i.yellow_flag, out_data_i.blue_flag);
          mismatch_cnt_o++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data_i.ready_res !== exp_w.ready_res ||
              out_data_i.avg_angle !== exp_w.avg_angle ||
              out_data_i.yellow_flag !== exp_w.yellow_flag ||
              out_data_i.blue_flag !== exp_w.blue_flag) begin
            if (mismatch_cnt_o < REPORT_LIMIT)
              $display("result word %0d: expected ready=%0b avg=%0d y=%0b b=%0b, %s%0b%s",
                       word_idx, exp_w.ready_res, exp_w.avg_angle, exp_w.yellow_flag,
                       exp_w.blue_flag, "got ready=", out_data_i.ready_res,
                       $sformatf(" avg=%0d y=%0b b=%0b", out_data_i.avg_angle,
                                 out_data_i.yellow_flag, out_data_i.blue_flag));
            mismatch_cnt_o++;
          end
        end
        word_idx++;
      end
      if (in_valid_i && in_ready_i)
        expected_words.push_back(accumulate_sample(in_data_i));
    end
    pending_o = expected_words.size();
  end

endmodule

>>> test/accel_tilt_average_classifier_tb.sv
`timescale 1ns / 1ps
// Testbench top for the accelerometer tilt-average classifier: clock, reset,
// sample and register stimulus, result back-pressure and the verdict.
// Depends on atac_pkg, the block itself and atac_result_checker.
module accel_tilt_average_classifier_tb;
  import atac_pkg::*;

  localparam int ANGLE_FRAC     = 7;
  localparam int CORDIC_ITERS   = 16;
  localparam int REG_UNUSED     = 6;
  localparam int MAX_GAP        = 14;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_CYCLES     = 60;
  localparam int N_PHASES       = 7;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                pending;
  int                stall_cycles = 0;
  bit                idle_on  = 1'b1;
  bit                hold_req = 1'b0;
  logic signed [13:0] zoff_now = RST_Z_OFFSET;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  accel_tilt_average_classifier #(
    .ANGLE_FRAC_BITS  (ANGLE_FRAC),
    .CORDIC_ITERATIONS(CORDIC_ITERS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  atac_result_checker #(
    .ANGLE_FRAC_BITS  (ANGLE_FRAC),
    .CORDIC_ITERATIONS(CORDIC_ITERS)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .mismatch_cnt_o(mismatches),
    .pending_o     (pending)
  );

  // Any accepted word or register access counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  // Entered and left at a falling edge; valid stays high when the next word follows at once.
  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_sample(int y, int z);
    in_word_t w;
    w.accel_y_raw = 16'(y);
    w.accel_z_raw = 16'(z);
    send_word(w, draw_gap());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic reg_write(int idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (idx == REG_Z_OFFSET) zoff_now = value[13:0];
  endtask

  task automatic apply_config(int win, int zo, int yl, int yh, int bpl, int bnh);
    wait_drained();
    reg_write(REG_WINDOW_LEN, DATA_W'(win));
    reg_write(REG_Z_OFFSET, DATA_W'(zo));
    reg_write(REG_YELLOW_LOW, DATA_W'(yl));
    reg_write(REG_YELLOW_HIGH, DATA_W'(yh));
    reg_write(REG_BLUE_POS_LOW, DATA_W'(bpl));
    reg_write(REG_BLUE_NEG_HIGH, DATA_W'(bnh));
  endtask

  function automatic int rand_threshold();
    if ($urandom_range(0, 7) == 0) return int'(16'sh0 + $signed(16'($urandom)));
    return int'($urandom_range(0, 46080)) - 23040;
  endfunction

  function automatic int rand_extreme();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Realistic vectors around the current bias, full-range noise, zero y, zero z after the bias and extremes.
  function automatic in_word_t rand_sample();
    in_word_t w;
    int       zo;
    int       dy;
    int       dz;
    zo = int'(zoff_now);
    w.accel_y_raw = 16'($urandom);
    w.accel_z_raw = 16'($urandom);
    case ($urandom_range(0, 9))
      4: w.accel_y_raw = '0;
      5: begin
        dy = int'($urandom_range(0, 16)) - 8;
        dz = int'($urandom_range(0, 16)) - 8;
        w.accel_y_raw = 16'(dy);
        w.accel_z_raw = 16'(zo + dz);
      end
      6: w.accel_z_raw = 16'(zo);
      7: begin
        w.accel_y_raw = 16'(rand_extreme());
        w.accel_z_raw = 16'(rand_extreme());
      end
      8, 9: begin
        dy = int'($urandom_range(0, 4000)) - 2000;
        dz = int'($urandom_range(0, 4000)) - 2000;
        w.accel_y_raw = 16'(dy);
        w.accel_z_raw = 16'(zo + dz);
      end
      default: ;
    endcase
    return w;
  endfunction

  // Result side: random back-pressure, with one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int win;
    int n_items;
    int zo;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: window of ten, bias 334.
    send_sample(0, 334);          // zero vector after the bias
    send_sample(0, 1000);         // y already zero, no rotation
    send_sample(0, -1000);        // pointing straight down
    send_sample(100, -1000);      // negative z with y >= 0
    send_sample(-100, -1000);     // negative z with y < 0
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(32767, -32768);
    send_sample(-32768, 32767);
    send_sample(-32768, 334);     // completes the first window

    // A zero window acts as one; every band bound at its extreme.
    apply_config(0, -8192, -32768, 32767, 32767, -32768);
    send_sample(500, -8192);
    send_sample(-1, -8193);

    // Wide blue band, yellow only at exactly zero; then shrink the window mid-way.
    apply_config(50, 8191, 0, 0, -23040, 23040);
    send_sample(0, 8191);
    send_sample(1, 8191);
    send_sample(-32768, -32768);
    send_sample(32767, 8190);
    send_sample(-5, 8200);
    wait_drained();
    reg_write(REG_WINDOW_LEN, DATA_W'(3));
    send_sample(7, 8191);         // count already above the new window
    wait_drained();
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(-200, 9000);
    send_sample(300, 7000);
    send_sample(0, 0);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       win = 1;
        1:       win = 7;
        2:       win = 255;
        3:       win = 0;
        default: win = int'($urandom_range(1, 20));
      endcase
      zo = ($urandom_range(0, 3) == 0) ? int'($signed(14'($urandom))) :
                                         int'($urandom_range(0, 8192)) - 4096;
      idle_on = !(p == 1 || p == 4);
      apply_config(win, zo, rand_threshold(), rand_threshold(), rand_threshold(),
                   rand_threshold());
      n_items = (win == 255) ? 260 : 90;
      for (int k = 0; k < n_items; k++) begin
        if (p == 4 && k == 10) hold_req = 1'b1;
        if (p == 6 && k == 45) wait_drained();
        send_word(rand_sample(), draw_gap());
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/atac_pkg.sv
hdl/atac_regs.sv
hdl/atac_datapath.sv
hdl/atac_ctrl.sv
hdl/accel_tilt_average_classifier.sv
test/atac_result_checker.sv
test/accel_tilt_average_classifier_tb.sv
